FILE: sv/ppda_pkg.sv
// ppda_pkg: shared widths, angle constants, register map and the arctangent
// table for the point-pair direction angle block. No dependencies.
package ppda_pkg;

  localparam int COORD_WIDTH_DEF   = 20;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int PRE_SHIFT         = 24;
  localparam int ANG_WIDTH         = 16;
  localparam int DZ_WIDTH          = 8;
  localparam int Z_WIDTH           = 25;
  localparam int APB_DATA_WIDTH    = 32;
  localparam int APB_ADDR_WIDTH    = 3;
  localparam int DZ_RESET          = 3;

  // Register map: word index taken from paddr[2]
  localparam logic REG_DEAD_ZONE = 1'b0;

  // Angles in degrees with 6 fraction bits
  localparam logic signed [ANG_WIDTH:0] DEG90_Q6  = 17'sd5760;
  localparam logic signed [ANG_WIDTH:0] DEG180_Q6 = 17'sd11520;
  localparam logic signed [ANG_WIDTH:0] DEG270_Q6 = 17'sd17280;
  localparam logic signed [Z_WIDTH-1:0] Z_ROUND   = 25'sd512;
  localparam int Z_DROP = 10;

  typedef struct packed {
    logic vert;
    logic dx_neg;
    logic dy_neg;
  } ctl_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  function automatic logic signed [Z_WIDTH-1:0] atan_q16(input int idx);
    logic signed [Z_WIDTH-1:0] v;
    case (idx)
      0:  v = 25'sd2949120;
      1:  v = 25'sd1740967;
      2:  v = 25'sd919879;
      3:  v = 25'sd466945;
      4:  v = 25'sd234379;
      5:  v = 25'sd117305;
      6:  v = 25'sd58666;
      7:  v = 25'sd29335;
      8:  v = 25'sd14668;
      9:  v = 25'sd7334;
      10: v = 25'sd3667;
      11: v = 25'sd1833;
      12: v = 25'sd917;
      13: v = 25'sd458;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      20: v = 25'sd4;
      21: v = 25'sd2;
      22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/ppda_pt_if.sv
// ppda_pt_if: valid/ready channel carrying one point pair request.
// Depends on ppda_pkg for the default coordinate width.
interface ppda_pt_if #(
  parameter int CW = ppda_pkg::COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

FILE: sv/ppda_ang_if.sv
// ppda_ang_if: valid/ready channel carrying one direction angle result.
// Depends on ppda_pkg for the angle width.
interface ppda_ang_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ppda_pkg::ANG_WIDTH-1:0]  direction_deg;

  modport source (output valid, direction_deg, input ready);
  modport sink   (input valid, direction_deg, output ready);
endinterface

FILE: sv/point_pair_direction_angle.sv
// Throughput: one request per cycle unless out_ang.ready holds the pipeline; each
//   pipeline stage holds one request and moves on whenever the stage after it is
//   empty or moving, so bubbles collapse.
// Reset (rst_n low, synchronous): clear all stage valid bits, load dead_zone with 3.
// Depends on ppda_pkg, ppda_pt_if and ppda_ang_if.
module point_pair_direction_angle #(
  parameter int COORD_WIDTH   = ppda_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = ppda_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ppda_pt_if.sink                               in_pts,
  ppda_ang_if.source                            out_ang,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [ppda_pkg::APB_ADDR_WIDTH-1:0]   cfg_paddr,
  input  logic [ppda_pkg::APB_DATA_WIDTH-1:0]   cfg_pwdata,
  output logic [ppda_pkg::APB_DATA_WIDTH-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);

  // Difference width, and the CORDIC datapath width: the difference scaled up
  // by the pre-shift, plus two bits for the CORDIC gain and the sign.
  localparam int DW  = COORD_WIDTH + 1;
  localparam int W   = DW + ppda_pkg::PRE_SHIFT + 2;
  localparam int N   = CORDIC_STAGES;
  // Stage map: 0 = differences, 1 = CORDIC setup, 2..N+1 = CORDIC, N+2 = output
  localparam int L   = N + 3;
  localparam int TW  = ppda_pkg::Z_WIDTH - ppda_pkg::Z_DROP;
  localparam int AW  = ppda_pkg::ANG_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration register. The APB access phase writes; pready is tied high.
  // ---------------------------------------------------------------------------
  logic [ppda_pkg::DZ_WIDTH-1:0] dz_r;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= ppda_pkg::DZ_WIDTH'(ppda_pkg::DZ_RESET);
    end else if (cfg_wr && cfg_paddr[2] == ppda_pkg::REG_DEAD_ZONE) begin
      dz_r <= cfg_pwdata[ppda_pkg::DZ_WIDTH-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ppda_pkg::REG_DEAD_ZONE) begin
      cfg_prdata = ppda_pkg::APB_DATA_WIDTH'(dz_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. A stage takes new data when it is empty or when the stage
  // after it moves; the last stage moves when the consumer takes the result.
  // ---------------------------------------------------------------------------
  logic [L-1:0] v_r;
  logic [L-1:0] v_nxt;
  logic [L:0]   rdy;

  assign rdy[L] = out_ang.ready;
  for (genvar j = 0; j < L; j++) begin : g_rdy
    assign rdy[j] = ~v_r[j] | rdy[j+1];
  end

  always_comb begin
    for (int j = 0; j < L; j++) begin
      if (rdy[j]) begin
        v_nxt[j] = (j == 0) ? in_pts.valid : v_r[(j == 0) ? 0 : j - 1];
      end else begin
        v_nxt[j] = v_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_pts.ready  = rdy[0];
  assign out_ang.valid = v_r[L-1];

  // ---------------------------------------------------------------------------
  // Stage 0: coordinate differences, exact in COORD_WIDTH+1 bits.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] dx_r;
  logic signed [DW-1:0] dy_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx_r <= DW'(in_pts.second_x) - DW'(in_pts.first_x);
      dy_r <= DW'(in_pts.second_y) - DW'(in_pts.first_y);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: dead-zone test and CORDIC setup. Fold a left-pointing vector into
  // the right half plane by negating both components, then scale by 2^24.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]               x_r   [0:N];
  logic signed [W-1:0]               y_r   [0:N];
  logic signed [ppda_pkg::Z_WIDTH-1:0] z_r [0:N];
  ppda_pkg::ctl_t                    ctl_r [0:N];

  logic [DW-1:0]        adx;
  logic signed [DW-1:0] ysel;
  logic                 dx_neg;
  ppda_pkg::ctl_t       ctl_nxt;

  assign dx_neg = dx_r[DW-1];
  assign adx    = dx_neg ? -dx_r : dx_r;
  assign ysel   = dx_neg ? -dy_r : dy_r;

  always_comb begin
    ctl_nxt.dx_neg = dx_neg;
    ctl_nxt.dy_neg = dy_r[DW-1];
    // Near-vertical, or exactly vertical when the dead zone is zero
    ctl_nxt.vert   = (adx < DW'(dz_r)) || (dx_r == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x_r[0]   <= {2'b00, adx, {ppda_pkg::PRE_SHIFT{1'b0}}};
      y_r[0]   <= {{2{ysel[DW-1]}}, ysel, {ppda_pkg::PRE_SHIFT{1'b0}}};
      z_r[0]   <= '0;
      ctl_r[0] <= ctl_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2..N+1: one CORDIC vectoring iteration each. Rotate toward y = 0
  // and accumulate the rotation angle in degrees.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < N; k++) begin : g_cordic
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;

    assign xs = x_r[k] >>> k;
    assign ys = y_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (rdy[k+2]) begin
        if (!y_r[k][W-1]) begin
          x_r[k+1] <= x_r[k] + ys;
          y_r[k+1] <= y_r[k] - xs;
          z_r[k+1] <= z_r[k] + ppda_pkg::atan_q16(k);
        end else begin
          x_r[k+1] <= x_r[k] - ys;
          y_r[k+1] <= y_r[k] + xs;
          z_r[k+1] <= z_r[k] - ppda_pkg::atan_q16(k);
        end
        ctl_r[k+1] <= ctl_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage N+2: round the angle to 6 fraction bits (half up), clamp to +-90,
  // apply the quadrant offset or the vertical answer, and register the result.
  // ---------------------------------------------------------------------------
  logic signed [ppda_pkg::Z_WIDTH-1:0] z_rnd;
  logic signed [TW-1:0]                t_raw;
  logic signed [AW:0]                  t_sat;
  logic signed [AW:0]                  res_nxt;
  logic signed [AW-1:0]                res_r;
  ppda_pkg::ctl_t                      ctl_f;

  assign ctl_f = ctl_r[N];
  assign z_rnd = z_r[N] + ppda_pkg::Z_ROUND;
  assign t_raw = z_rnd[ppda_pkg::Z_WIDTH-1:ppda_pkg::Z_DROP];

  always_comb begin
    t_sat = (AW+1)'(t_raw);
    if (t_sat > ppda_pkg::DEG90_Q6) begin
      t_sat = ppda_pkg::DEG90_Q6;
    end else if (t_sat < -ppda_pkg::DEG90_Q6) begin
      t_sat = -ppda_pkg::DEG90_Q6;
    end

    if (ctl_f.vert) begin
      res_nxt = ctl_f.dy_neg ? ppda_pkg::DEG270_Q6 : ppda_pkg::DEG90_Q6;
    end else if (ctl_f.dx_neg) begin
      res_nxt = ctl_f.dy_neg ? (t_sat - ppda_pkg::DEG180_Q6) : (t_sat + ppda_pkg::DEG180_Q6);
    end else begin
      res_nxt = t_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[L-1]) begin
      res_r <= res_nxt[AW-1:0];
    end
  end

  assign out_ang.direction_deg = res_r;

endmodule

FILE: sv/ppda_chk.sv
// ppda_chk: port-level checks on the point-pair direction angle block, and
// the bind that attaches them. Depends on ppda_pkg and the top level.
module ppda_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [ppda_pkg::ANG_WIDTH-1:0] out_deg
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty output stage lets every stage move, so a request is always taken
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output stage");

  // Angles stay within the clamp plus the half-turn offset
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_deg >= -16'sd17280 && out_deg <= 16'sd17280))
    else $error("direction angle out of range");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_deg))
    else $error("stalled result changed or dropped");

endmodule

bind point_pair_direction_angle ppda_chk u_ppda_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pts.ready),
  .out_valid (out_ang.valid),
  .out_ready (out_ang.ready),
  .out_deg   (out_ang.direction_deg)
);
